// ===== rtl/core/chr_latch_bank_mapper_top_macros.svh =====
// -----------------------------------------------------------------------------
// chr_latch_bank_mapper_top_macros
// Assertion macros used by the mapper top module.
// -----------------------------------------------------------------------------
`ifndef CHR_LATCH_BANK_MAPPER_TOP_MACROS_SVH
`define CHR_LATCH_BANK_MAPPER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define CLBM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define CLBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/chr_lbm_pkg.sv =====
// -----------------------------------------------------------------------------
// chr_lbm_pkg
// Types and constants for the picture-latch bank mapper.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package chr_lbm_pkg;

   localparam int unsigned BankWidth    = 8;
   localparam int unsigned PrgBankCount = 3;
   localparam int unsigned ChrBankCount = 4;

   // access kinds
   localparam logic ACTION_CPU_WRITE = 1'b0;
   localparam logic ACTION_CHR_READ  = 1'b1;

   // tile offsets inside the 1 KB window that trip a latch
   localparam logic [9:0] LATCH_SET_OFFSET  = 10'h3D8;
   localparam logic [9:0] LATCH_CLR_OFFSET  = 10'h3E8;
   localparam logic [9:0] HIGH_OFFSET_MASK  = 10'h3F8;

   // 1 KB windows that hold the latch tiles
   localparam logic [3:0] LOW_LATCH_WINDOW  = 4'd3;
   localparam logic [3:0] HIGH_LATCH_WINDOW = 4'd7;

   // program bank register indexes
   localparam logic [1:0] PRG_IDX_8000 = 2'd0;
   localparam logic [1:0] PRG_IDX_A000 = 2'd1;
   localparam logic [1:0] PRG_IDX_C000 = 2'd2;

   typedef logic [BankWidth-1:0] bank_type;

   // decoded update for one access
   typedef struct packed {
      logic       prg_we;
      logic [1:0] prg_idx;
      logic       chr_we;
      logic [1:0] chr_idx;
      bank_type   data;
      logic       lo_set;
      logic       lo_clr;
      logic       hi_set;
      logic       hi_clr;
      logic       serve_low;
      logic       serve_high;
   } bank_cmd_type;

   // bank selection after an access
   typedef struct packed {
      bank_type [PrgBankCount-1:0] prg;
      bank_type                    chr_low;
      bank_type                    chr_high;
      bank_type                    served;
      logic                        latch_lo;
      logic                        latch_hi;
   } bank_view_type;

endpackage

// ===== rtl/core/chr_latch_bank_mapper_top.sv =====
// Picture-latch bank mapper. Takes one bus access (CPU write or picture read)
// per clock and returns one result beat per access. An accepted access sits
// in the input register, then goes through the bank update into the result
// register. Throughput is one access every cycle as long as the result side
// does not stall; the result register lets a new access enter while a
// finished result is still waiting. Each result shows the program banks,
// the latch-selected picture banks and the mirroring mode as they stand
// after the access, plus the bank that served a picture read before any
// latch change (zero for writes and for reads with address[13:0] >= $2000).
// -----------------------------------------------------------------------------
// chr_latch_bank_mapper_top
// Input register, bank update logic and result register.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "chr_latch_bank_mapper_top_macros.svh"

module chr_latch_bank_mapper_top
   import chr_lbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_prg_bank_8000,
   output logic [7:0]  rsp_prg_bank_a000,
   output logic [7:0]  rsp_prg_bank_c000,
   output logic [7:0]  rsp_chr_bank_low,
   output logic [7:0]  rsp_chr_bank_high,
   output logic [1:0]  rsp_mirroring,
   output logic [7:0]  rsp_read_chr_bank
);

   logic          s1_valid_ff, s1_valid_in;
   logic          action_ff;
   logic [15:0]   address_ff;
   logic [7:0]    data_ff;
   logic          req_accept;
   logic          s1_advance;
   logic          rsp_valid_ff, rsp_valid_in;
   bank_view_type view;
   bank_view_type view_ff;
   bank_cmd_type  cmd;

   // move the input beat on when the result register is free or being taken
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // hold the accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         action_ff  <= req_action;
         address_ff <= req_address;
         data_ff    <= req_data;
      end
   end

   chr_lbm_decode u_decode (
      .action  (action_ff),
      .address (address_ff),
      .data    (data_ff),
      .cmd     (cmd)
   );

   chr_lbm_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .advance (s1_advance),
      .cmd     (cmd),
      .view    (view)
   );

   // result register: load on advance, drop once taken
   always_comb begin
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         view_ff <= view;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_prg_bank_8000 = view_ff.prg[0];
   assign rsp_prg_bank_a000 = view_ff.prg[1];
   assign rsp_prg_bank_c000 = view_ff.prg[2];
   assign rsp_chr_bank_low  = view_ff.chr_low;
   assign rsp_chr_bank_high = view_ff.chr_high;
   assign rsp_mirroring     = view_ff.chr_low[BankWidth-1:BankWidth-2];
   assign rsp_read_chr_bank = view_ff.served;

   // checks
   `CLBM_ASSERT_NEXT(a_adv_fills_rsp, clock, reset, s1_advance, rsp_valid_ff, "advanced beat lost")
   `CLBM_ASSERT_NOW(a_stall_needs_beat, clock, reset, req_stall, s1_valid_ff && rsp_valid_ff, "stall without a held beat")
   `CLBM_ASSERT_NEXT(a_lo_latch_set, clock, reset, s1_advance && cmd.lo_set, view.latch_lo, "low latch not set")
   `CLBM_ASSERT_NEXT(a_hi_latch_clr, clock, reset, s1_advance && cmd.hi_clr, !view.latch_hi, "high latch not cleared")

endmodule

// ===== rtl/core/chr_lbm_decode.sv =====
// -----------------------------------------------------------------------------
// chr_lbm_decode
// Decode one bus access into register writes and latch updates.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chr_lbm_decode
   import chr_lbm_pkg::*;
(
   input  logic         action,
   input  logic [15:0]  address,
   input  logic [7:0]   data,
   output bank_cmd_type cmd
);

   logic        is_write;
   logic        is_read;
   logic [13:0] pa;
   logic [3:0]  kb;
   logic [9:0]  off;
   logic [9:0]  off_hi;
   logic        top_window;

   assign is_write   = (action == ACTION_CPU_WRITE);
   assign is_read    = (action == ACTION_CHR_READ);
   assign pa         = address[13:0];
   assign kb         = pa[13:10];
   assign off        = pa[9:0];
   assign off_hi     = pa[9:0] & HIGH_OFFSET_MASK;
   assign top_window = (address[15:13] == 3'b111);

   // map CPU writes onto the bank registers
   always_comb begin
      cmd.prg_we  = is_write && address[15] && !top_window;
      cmd.prg_idx = address[14:13];
      cmd.chr_we  = is_write && top_window;
      cmd.chr_idx = address[11:10];
      cmd.data    = data;
   end

   // latch tiles and the half serving a picture read
   always_comb begin
      cmd.lo_set     = is_read && (kb == LOW_LATCH_WINDOW) && (off == LATCH_SET_OFFSET);
      cmd.lo_clr     = is_read && (kb == LOW_LATCH_WINDOW) && (off == LATCH_CLR_OFFSET);
      cmd.hi_set     = is_read && (kb == HIGH_LATCH_WINDOW) && (off_hi == LATCH_SET_OFFSET);
      cmd.hi_clr     = is_read && (kb == HIGH_LATCH_WINDOW) && (off_hi == LATCH_CLR_OFFSET);
      cmd.serve_low  = is_read && (pa[13:12] == 2'b00);
      cmd.serve_high = is_read && (pa[13:12] == 2'b01);
   end

endmodule

// ===== rtl/core/chr_lbm_regs.sv =====
// -----------------------------------------------------------------------------
// chr_lbm_regs
// Program and picture bank registers plus the two half latches.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chr_lbm_regs
   import chr_lbm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  bank_cmd_type  cmd,
   output bank_view_type view
);

   bank_type [PrgBankCount-1:0] prg_ff, prg_in;
   bank_type [ChrBankCount-1:0] chr_ff, chr_in;
   logic                        latch_lo_ff, latch_lo_in;
   logic                        latch_hi_ff, latch_hi_in;

   // apply register writes
   always_comb begin
      prg_in = prg_ff;
      chr_in = chr_ff;
      if (cmd.prg_we) begin
         case (cmd.prg_idx)
            PRG_IDX_8000: prg_in[0] = cmd.data;
            PRG_IDX_A000: prg_in[1] = cmd.data;
            PRG_IDX_C000: prg_in[2] = cmd.data;
            default:      prg_in    = prg_ff;
         endcase
      end
      if (cmd.chr_we) begin
         chr_in[cmd.chr_idx] = cmd.data;
      end
   end

   // set or clear the latches on their tiles
   always_comb begin
      latch_lo_in = latch_lo_ff;
      latch_hi_in = latch_hi_ff;
      if (cmd.lo_set) begin
         latch_lo_in = 1'b1;
      end else if (cmd.lo_clr) begin
         latch_lo_in = 1'b0;
      end
      if (cmd.hi_set) begin
         latch_hi_in = 1'b1;
      end else if (cmd.hi_clr) begin
         latch_hi_in = 1'b0;
      end
   end

   // hold state, advance with each beat
   always_ff @(posedge clock) begin
      if (reset) begin
         prg_ff      <= '0;
         chr_ff      <= '0;
         latch_lo_ff <= 1'b0;
         latch_hi_ff <= 1'b0;
      end else if (advance) begin
         prg_ff      <= prg_in;
         chr_ff      <= chr_in;
         latch_lo_ff <= latch_lo_in;
         latch_hi_ff <= latch_hi_in;
      end
   end

   // report banks after the access; the served bank uses the old latch
   always_comb begin
      view.prg      = prg_in;
      view.chr_low  = chr_in[{1'b0, latch_lo_in}];
      view.chr_high = chr_in[{1'b1, latch_hi_in}];
      view.latch_lo = latch_lo_ff;
      view.latch_hi = latch_hi_ff;
      if (cmd.serve_low) begin
         view.served = chr_ff[{1'b0, latch_lo_ff}];
      end else if (cmd.serve_high) begin
         view.served = chr_ff[{1'b1, latch_hi_ff}];
      end else begin
         view.served = '0;
      end
   end

endmodule

// ===== bench/chr_latch_bank_mapper_top_test.sv =====
// -----------------------------------------------------------------------------
// chr_latch_bank_mapper_top_test
// Self-checking bench for the picture-latch bank mapper. A directed table
// walks the register decode, latch tiles, wide picture addresses and the
// nametable region. Random accesses then follow under four idle/stall mixes.
// Every result beat is compared field by field with a typed or modelled value.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chr_latch_bank_mapper_top_test;
   import chr_lbm_pkg::*;

   typedef struct packed {
      logic        action;
      logic [15:0] address;
      logic [7:0]  data;
   } bus_access_type;

   typedef struct packed {
      bank_type   prg_8000;
      bank_type   prg_a000;
      bank_type   prg_c000;
      bank_type   chr_low;
      bank_type   chr_high;
      logic [1:0] mirroring;
      bank_type   read_bank;
   } bank_result_type;

   typedef struct {
      bus_access_type  acc;
      bit              typed;
      bank_result_type want;
   } access_row_type;

   localparam int unsigned CycleLimit    = 200000;
   localparam int unsigned ItemsPerPhase = 144;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_action;
   logic [15:0] req_address;
   logic [7:0]  req_data;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_prg_bank_8000;
   logic [7:0]  rsp_prg_bank_a000;
   logic [7:0]  rsp_prg_bank_c000;
   logic [7:0]  rsp_chr_bank_low;
   logic [7:0]  rsp_chr_bank_high;
   logic [1:0]  rsp_mirroring;
   logic [7:0]  rsp_read_chr_bank;

   // mapper state as the bench sees it
   bank_type prg_regs [3];
   bank_type chr_regs [4];
   logic     chr_latch [2];

   bank_result_type bank_results_q [$];
   access_row_type  access_table [$];

   int unsigned idle_pct;
   int unsigned stall_pct;
   int unsigned cycle_count = 0;
   int unsigned fail_count = 0;

   chr_latch_bank_mapper_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_address       (req_address),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_prg_bank_8000 (rsp_prg_bank_8000),
      .rsp_prg_bank_a000 (rsp_prg_bank_a000),
      .rsp_prg_bank_c000 (rsp_prg_bank_c000),
      .rsp_chr_bank_low  (rsp_chr_bank_low),
      .rsp_chr_bank_high (rsp_chr_bank_high),
      .rsp_mirroring     (rsp_mirroring),
      .rsp_read_chr_bank (rsp_read_chr_bank)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Apply one access to the bank model and return the banks it reports
   function automatic bank_result_type apply_access(bus_access_type a);
      bank_result_type r;
      logic [13:0]     pic_addr;
      logic [3:0]      window;
      logic [9:0]      offset;
      pic_addr    = a.address[13:0];
      window      = pic_addr[13:10];
      offset      = pic_addr[9:0];
      r.read_bank = '0;
      if (a.action == ACTION_CPU_WRITE) begin
         if (a.address >= 16'hE000) begin
            chr_regs[a.address[11:10]] = a.data;
         end else if (a.address >= 16'h8000) begin
            prg_regs[a.address[14:13]] = a.data;
         end
      end else begin
         // serving bank is taken before any latch flip
         if (pic_addr < 14'h1000) begin
            r.read_bank = chr_regs[{1'b0, chr_latch[0]}];
         end else if (pic_addr < 14'h2000) begin
            r.read_bank = chr_regs[{1'b1, chr_latch[1]}];
         end
         if (window == LOW_LATCH_WINDOW) begin
            if (offset == LATCH_SET_OFFSET) chr_latch[0] = 1'b1;
            else if (offset == LATCH_CLR_OFFSET) chr_latch[0] = 1'b0;
         end else if (window == HIGH_LATCH_WINDOW) begin
            if ((offset & HIGH_OFFSET_MASK) == LATCH_SET_OFFSET) chr_latch[1] = 1'b1;
            else if ((offset & HIGH_OFFSET_MASK) == LATCH_CLR_OFFSET) chr_latch[1] = 1'b0;
         end
      end
      r.prg_8000  = prg_regs[PRG_IDX_8000];
      r.prg_a000  = prg_regs[PRG_IDX_A000];
      r.prg_c000  = prg_regs[PRG_IDX_C000];
      r.chr_low   = chr_regs[{1'b0, chr_latch[0]}];
      r.chr_high  = chr_regs[{1'b1, chr_latch[1]}];
      r.mirroring = r.chr_low[7:6];
      return r;
   endfunction

   // Draw a random access, mostly aimed at registers and latch tiles
   function automatic bus_access_type random_access();
      bus_access_type a;
      int unsigned    pick;
      pick      = $urandom_range(0, 99);
      a.data    = 8'($urandom_range(0, 255));
      a.action  = ACTION_CHR_READ;
      a.address = 16'($urandom_range(0, 16'h1FFF));
      if (pick < 20) begin
         a.action  = ACTION_CPU_WRITE;
         a.address = 16'h8000 + 16'($urandom_range(0, 16'h5FFF));
      end else if (pick < 40) begin
         a.action  = ACTION_CPU_WRITE;
         a.address = {3'b111, 13'($urandom_range(0, 16'h1FFF))};
      end else if (pick < 45) begin
         a.action  = ACTION_CPU_WRITE;
         a.address = 16'($urandom_range(0, 16'hFFFF));
      end else if (pick < 70) begin
         case ($urandom_range(0, 3))
            0:       a.address = 16'h0FD8;
            1:       a.address = 16'h0FE8;
            2:       a.address = 16'h1FD8 | 16'($urandom_range(0, 7));
            default: a.address = 16'h1FE8 | 16'($urandom_range(0, 7));
         endcase
         // sometimes set the bits above the 14-bit picture bus
         if ($urandom_range(0, 3) == 0) a.address[15:14] = 2'($urandom_range(0, 3));
      end else if (pick >= 95) begin
         a.address = 16'($urandom_range(0, 16'hFFFF));
      end
      return a;
   endfunction

   task automatic add_typed_row(input logic act, input logic [15:0] addr,
                                input logic [7:0] dat, input bank_result_type want);
      access_row_type row;
      row.acc   = '{act, addr, dat};
      row.typed = 1'b1;
      row.want  = want;
      access_table.push_back(row);
   endtask

   task automatic add_row(input logic act, input logic [15:0] addr, input logic [7:0] dat);
      access_row_type row;
      row.acc   = '{act, addr, dat};
      row.typed = 1'b0;
      row.want  = '0;
      access_table.push_back(row);
   endtask

   // Offer one access beat, hold it until taken, then log its expected result
   task automatic send_access(input bus_access_type a, input bit typed,
                              input bank_result_type want);
      bank_result_type predicted;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= a.action;
      req_address <= a.address;
      req_data    <= a.data;
      do @(posedge clock); while (req_stall);
      predicted = apply_access(a);
      bank_results_q.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         fail_count++;
      end
   endtask

   // Stall the result side at the current rate
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Compare each result beat with the oldest expectation
   always @(posedge clock) begin
      bank_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (bank_results_q.size() == 0) begin
            $error("result beat with no access waiting");
            fail_count++;
         end else begin
            want = bank_results_q.pop_front();
            check_field("prg_bank_8000", want.prg_8000, rsp_prg_bank_8000);
            check_field("prg_bank_a000", want.prg_a000, rsp_prg_bank_a000);
            check_field("prg_bank_c000", want.prg_c000, rsp_prg_bank_c000);
            check_field("chr_bank_low", want.chr_low, rsp_chr_bank_low);
            check_field("chr_bank_high", want.chr_high, rsp_chr_bank_high);
            check_field("mirroring", {6'd0, want.mirroring}, {6'd0, rsp_mirroring});
            check_field("read_chr_bank", want.read_bank, rsp_read_chr_bank);
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_action  <= ACTION_CPU_WRITE;
      req_address <= '0;
      req_data    <= '0;
      idle_pct    = 0;
      stall_pct   = 0;
      for (int i = 0; i < 3; i++) prg_regs[i] = '0;
      for (int i = 0; i < 4; i++) chr_regs[i] = '0;
      chr_latch[0] = 1'b0;
      chr_latch[1] = 1'b0;

      // register decode: values read off directly
      add_typed_row(ACTION_CHR_READ,  16'h0000, 8'h00,
                    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0, 8'h00});
      add_typed_row(ACTION_CPU_WRITE, 16'h8000, 8'hFF,
                    '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0, 8'h00});
      add_typed_row(ACTION_CPU_WRITE, 16'hA000, 8'h01,
                    '{8'hFF, 8'h01, 8'h00, 8'h00, 8'h00, 2'd0, 8'h00});
      add_typed_row(ACTION_CPU_WRITE, 16'hDFFF, 8'h80,
                    '{8'hFF, 8'h01, 8'h80, 8'h00, 8'h00, 2'd0, 8'h00});
      add_typed_row(ACTION_CPU_WRITE, 16'h7FFF, 8'hAA,
                    '{8'hFF, 8'h01, 8'h80, 8'h00, 8'h00, 2'd0, 8'h00});
      add_typed_row(ACTION_CPU_WRITE, 16'hE000, 8'hC1,
                    '{8'hFF, 8'h01, 8'h80, 8'hC1, 8'h00, 2'd3, 8'h00});
      add_typed_row(ACTION_CPU_WRITE, 16'hE400, 8'h42,
                    '{8'hFF, 8'h01, 8'h80, 8'hC1, 8'h00, 2'd3, 8'h00});
      add_typed_row(ACTION_CPU_WRITE, 16'hE800, 8'h13,
                    '{8'hFF, 8'h01, 8'h80, 8'hC1, 8'h13, 2'd3, 8'h00});
      add_typed_row(ACTION_CPU_WRITE, 16'hFFFF, 8'h7E,
                    '{8'hFF, 8'h01, 8'h80, 8'hC1, 8'h13, 2'd3, 8'h00});
      // low latch: exact tile addresses only, flip lands after the read
      add_row(ACTION_CHR_READ, 16'h0FD8, 8'h00);
      add_row(ACTION_CHR_READ, 16'h0123, 8'h00);
      add_row(ACTION_CHR_READ, 16'h0FE8, 8'h00);
      add_row(ACTION_CHR_READ, 16'h0FD9, 8'h00);
      add_row(ACTION_CHR_READ, 16'h0BD8, 8'h00);
      // high latch: any address in the eight-byte tile rows
      add_row(ACTION_CHR_READ, 16'h1FDF, 8'h00);
      add_row(ACTION_CHR_READ, 16'h1FD0, 8'h00);
      add_row(ACTION_CHR_READ, 16'h1FE8, 8'h00);
      add_row(ACTION_CHR_READ, 16'h1FD8, 8'h00);
      add_row(ACTION_CHR_READ, 16'h1FEF, 8'h00);
      // nametable region serves nothing; wide addresses fold onto the bus
      add_row(ACTION_CHR_READ, 16'h2FD8, 8'h00);
      add_row(ACTION_CHR_READ, 16'h4FD8, 8'h00);
      add_row(ACTION_CHR_READ, 16'hFFFF, 8'hFF);
      add_row(ACTION_CHR_READ, 16'h1000, 8'hFF);
      add_row(ACTION_CPU_WRITE, 16'hC000, 8'h00);
      add_row(ACTION_CPU_WRITE, 16'h9FFF, 8'h55);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (access_table[i]) begin
         send_access(access_table[i].acc, access_table[i].typed, access_table[i].want);
      end

      // random accesses under each idle/stall mix
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 65; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 65; end
            default: begin idle_pct = 21; stall_pct = 21; end
         endcase
         for (int n = 0; n < ItemsPerPhase; n++) begin
            send_access(random_access(), 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      // drain outstanding results, then let the pipeline settle
      while (bank_results_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && bank_results_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/chr_lbm_pkg.sv
rtl/core/chr_lbm_decode.sv
rtl/core/chr_lbm_regs.sv
rtl/core/chr_latch_bank_mapper_top.sv
bench/chr_latch_bank_mapper_top_test.sv
